### design/psnd_pkg.sv
// Shared types and sizes for the point to segment nearest distance block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package psnd_pkg;

  localparam int CW   = 32;          // coordinate width, signed fixed point
  localparam int DW   = CW + 1;      // coordinate difference width
  localparam int PW   = 2 * DW;      // product of two differences
  localparam int NW   = PW + 1;      // dot product sums
  localparam int REMW = NW + 1;      // divider remainder
  localparam int TB   = CW + 2;      // fraction bits of the projection parameter
  localparam int TW   = TB + 1;      // projection parameter, 0 .. 1 inclusive
  localparam int MW   = TW + DW;     // parameter times a difference
  localparam int RW   = DW + 2;      // residual from the query point
  localparam int RS   = DW + 1;      // square root steps, two radicand bits each
  localparam int SQW  = 2 * RS;      // radicand, padded to an even width
  localparam int DSW  = CW + 1;      // distance field width
  localparam int QD   = 4;           // queue depth
  localparam int QAW  = $clog2(QD);

  typedef enum logic [1:0] {
    CLS_ZERO,   // projection at or before the start, or coinciding end points
    CLS_ONE,    // projection at or past the end
    CLS_DIV     // projection inside, parameter from the divider
  } cls_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
    cls_t                 cls;
    logic                 degen;
  } div_side_t;

  typedef struct packed {
    div_side_t         side;
    logic [REMW-1:0]   rem;
    logic [NW-1:0]     den;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    logic                 degen;
  } root_side_t;

endpackage
`default_nettype wire

### design/psnd_front.sv
// Front part: takes items, forms differences and dot products, classifies.
// Depends on psnd_pkg; feeds psnd_queue.
`default_nettype none
module psnd_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [psnd_pkg::CW-1:0] point_x,
  input  wire logic signed [psnd_pkg::CW-1:0] point_y,
  input  wire logic signed [psnd_pkg::CW-1:0] start_x,
  input  wire logic signed [psnd_pkg::CW-1:0] start_y,
  input  wire logic signed [psnd_pkg::CW-1:0] end_x,
  input  wire logic signed [psnd_pkg::CW-1:0] end_y,
  input  wire psnd_pkg::q_stat_t              q_stat,
  output logic                                push,
  output psnd_pkg::q_entry_t                  entry
);

  logic en;
  logic f0_valid, f1_valid, f2_valid;
  psnd_pkg::div_side_t f0_side, f1_side, f2_side;
  logic signed [psnd_pkg::PW-1:0] f1_dxvx, f1_dyvy, f1_dxdx, f1_dydy;
  logic signed [psnd_pkg::NW-1:0] f2_num, f2_den;
  logic degen, nonpos, past_end;

  assign en       = !(f2_valid && q_stat.full);
  assign in_stall = !en;
  assign push     = f2_valid && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_valid <= 1'b0;
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f0_valid <= in_valid;
      f1_valid <= f0_valid;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_side.sx    <= start_x;
      f0_side.sy    <= start_y;
      f0_side.dx    <= psnd_pkg::DW'(end_x) - psnd_pkg::DW'(start_x);
      f0_side.dy    <= psnd_pkg::DW'(end_y) - psnd_pkg::DW'(start_y);
      f0_side.vx    <= psnd_pkg::DW'(point_x) - psnd_pkg::DW'(start_x);
      f0_side.vy    <= psnd_pkg::DW'(point_y) - psnd_pkg::DW'(start_y);
      f0_side.cls   <= psnd_pkg::CLS_ZERO;
      f0_side.degen <= 1'b0;
      f1_side       <= f0_side;
      f1_dxvx       <= f0_side.dx * f0_side.vx;
      f1_dyvy       <= f0_side.dy * f0_side.vy;
      f1_dxdx       <= f0_side.dx * f0_side.dx;
      f1_dydy       <= f0_side.dy * f0_side.dy;
      f2_side       <= f1_side;
      f2_num        <= psnd_pkg::NW'(f1_dxvx) + psnd_pkg::NW'(f1_dyvy);
      f2_den        <= psnd_pkg::NW'(f1_dxdx) + psnd_pkg::NW'(f1_dydy);
    end
  end

  assign degen    = (f2_side.dx == '0) && (f2_side.dy == '0);
  assign nonpos   = f2_num[psnd_pkg::NW-1] || (f2_num == '0);
  assign past_end = f2_num >= f2_den;

  always_comb begin
    entry            = '0;
    entry.side       = f2_side;
    entry.side.degen = degen;
    entry.den        = f2_den;
    priority if (degen || nonpos) begin
      entry.side.cls = psnd_pkg::CLS_ZERO;
    end else if (past_end) begin
      entry.side.cls = psnd_pkg::CLS_ONE;
    end else begin
      entry.side.cls = psnd_pkg::CLS_DIV;
      entry.rem      = psnd_pkg::REMW'(f2_num);
    end
  end

endmodule
`default_nettype wire

### design/psnd_queue.sv
// Short queue between the front and back parts of the block.
// Depends on psnd_pkg.
`default_nettype none
module psnd_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire psnd_pkg::q_entry_t entry,
  input  wire logic               pop,
  output psnd_pkg::q_entry_t      head,
  output psnd_pkg::q_stat_t       q_stat
);

  psnd_pkg::q_entry_t slots [psnd_pkg::QD];
  logic [psnd_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic [psnd_pkg::QAW:0]   count;

  assign q_stat.full  = count == (psnd_pkg::QAW+1)'(psnd_pkg::QD);
  assign q_stat.empty = count == '0;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (psnd_pkg::QAW+1)'(push) - (psnd_pkg::QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_stat.empty)) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (psnd_pkg::QAW+1)'(psnd_pkg::QD)) else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr == rd_ptr) |-> (q_stat.full || q_stat.empty))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

### design/psnd_divider.sv
// Pipelined restoring divider for the projection parameter, one bit a stage.
// Depends on psnd_pkg.
`default_nettype none
module psnd_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire psnd_pkg::q_entry_t         in_entry,
  output logic                            out_valid,
  output logic [psnd_pkg::TB-1:0]         quo_out,
  output psnd_pkg::div_side_t             side_out
);

  logic                      vld  [psnd_pkg::TB];
  logic [psnd_pkg::REMW-1:0] rem  [psnd_pkg::TB];
  logic [psnd_pkg::NW-1:0]   den  [psnd_pkg::TB];
  logic [psnd_pkg::TB-1:0]   quo  [psnd_pkg::TB];
  psnd_pkg::div_side_t       side [psnd_pkg::TB];

  for (genvar k = 0; k < psnd_pkg::TB; k++) begin : g_stage
    logic                      pv;
    logic [psnd_pkg::REMW-1:0] pr;
    logic [psnd_pkg::NW-1:0]   pd;
    logic [psnd_pkg::TB-1:0]   pq;
    psnd_pkg::div_side_t       ps;
    logic [psnd_pkg::REMW-1:0] r2;
    logic                      ge;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign pr = in_entry.rem;
      assign pd = in_entry.den;
      assign pq = '0;
      assign ps = in_entry.side;
    end else begin : g_next
      assign pv = vld[k-1];
      assign pr = rem[k-1];
      assign pd = den[k-1];
      assign pq = quo[k-1];
      assign ps = side[k-1];
    end

    assign r2 = {pr[psnd_pkg::REMW-2:0], 1'b0};
    assign ge = r2 >= psnd_pkg::REMW'(pd);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? r2 - psnd_pkg::REMW'(pd) : r2;
        den[k]  <= pd;
        quo[k]  <= {pq[psnd_pkg::TB-2:0], ge};
        side[k] <= ps;
      end
    end
  end

  assign out_valid = vld[psnd_pkg::TB-1];
  assign quo_out   = quo[psnd_pkg::TB-1];
  assign side_out  = side[psnd_pkg::TB-1];

endmodule
`default_nettype wire

### design/psnd_root.sv
// Pipelined integer square root, two radicand bits a stage.
// Depends on psnd_pkg.
`default_nettype none
module psnd_root (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [psnd_pkg::SQW-1:0] radicand,
  input  wire psnd_pkg::root_side_t   in_side,
  output logic                        out_valid,
  output logic [psnd_pkg::RS-1:0]     root_out,
  output psnd_pkg::root_side_t        side_out
);

  logic                       vld  [psnd_pkg::RS];
  logic [psnd_pkg::SQW-1:0]   rad  [psnd_pkg::RS];
  logic [psnd_pkg::RS:0]      rem  [psnd_pkg::RS];
  logic [psnd_pkg::RS-1:0]    root [psnd_pkg::RS];
  psnd_pkg::root_side_t       side [psnd_pkg::RS];

  for (genvar k = 0; k < psnd_pkg::RS; k++) begin : g_stage
    logic                     pv;
    logic [psnd_pkg::SQW-1:0] pa;
    logic [psnd_pkg::RS:0]    pr;
    logic [psnd_pkg::RS-1:0]  pt;
    psnd_pkg::root_side_t     ps;
    logic [psnd_pkg::RS+1:0]  cand, trial;
    logic                     ge;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign pa = radicand;
      assign pr = '0;
      assign pt = '0;
      assign ps = in_side;
    end else begin : g_next
      assign pv = vld[k-1];
      assign pa = rad[k-1];
      assign pr = rem[k-1];
      assign pt = root[k-1];
      assign ps = side[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign cand  = {pr[psnd_pkg::RS-1:0], pa[psnd_pkg::SQW-1 -: 2]};
    assign trial = {pt, 2'b01};
    assign ge    = cand >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k]  <= {pa[psnd_pkg::SQW-3:0], 2'b00};
        rem[k]  <= psnd_pkg::RS'(1) == 0 ? '0 :
                   (psnd_pkg::RS+1)'(ge ? cand - trial : cand);
        root[k] <= {pt[psnd_pkg::RS-2:0], ge};
        side[k] <= ps;
      end
    end
  end

  assign out_valid = vld[psnd_pkg::RS-1];
  assign root_out  = root[psnd_pkg::RS-1];
  assign side_out  = side[psnd_pkg::RS-1];

endmodule
`default_nettype wire

### design/psnd_back.sv
// Back part: divides, scales the offset, squares the residual, takes the root.
// Depends on psnd_pkg, psnd_divider and psnd_root.
`default_nettype none
module psnd_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire psnd_pkg::q_entry_t        head,
  input  wire psnd_pkg::q_stat_t         q_stat,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [psnd_pkg::CW-1:0] nearest_x,
  output logic signed [psnd_pkg::CW-1:0] nearest_y,
  output logic [psnd_pkg::DSW-1:0]       distance,
  output logic                           degenerate
);

  logic en;
  logic dv_valid;
  logic [psnd_pkg::TB-1:0] dv_quo;
  psnd_pkg::div_side_t dv_side;
  logic [psnd_pkg::TW-1:0] t;
  logic [psnd_pkg::DW-1:0] adx, ady;

  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  psnd_pkg::div_side_t s1_side, s2_side;
  logic [psnd_pkg::MW-1:0] s1_mx, s1_my;
  logic [psnd_pkg::DW-1:0] s2_qx, s2_qy;
  logic [psnd_pkg::MW:0]   mbx, mby;
  logic signed [psnd_pkg::RW-1:0] s3_rx, s3_ry;
  psnd_pkg::root_side_t s3_side, s4_side, s5_side, s6_side;
  logic [psnd_pkg::DW-1:0] s4_ax, s4_ay;
  logic [2*psnd_pkg::DW-1:0] s5_sx, s5_sy;
  logic [psnd_pkg::SQW-1:0] s6_sum;

  logic rt_valid;
  logic [psnd_pkg::RS-1:0] rt_root;
  psnd_pkg::root_side_t rt_side;

  localparam logic [psnd_pkg::MW:0] Bias = {{(psnd_pkg::MW+1-psnd_pkg::TB){1'b0}},
                                            {psnd_pkg::TB{1'b1}}};

  assign en  = !(out_valid && out_stall);
  assign pop = en && !q_stat.empty;

  psnd_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (!q_stat.empty),
    .in_entry  (head),
    .out_valid (dv_valid),
    .quo_out   (dv_quo),
    .side_out  (dv_side)
  );

  always_comb begin
    unique case (dv_side.cls)
      psnd_pkg::CLS_ONE: t = psnd_pkg::TW'(1) << psnd_pkg::TB;
      psnd_pkg::CLS_DIV: t = psnd_pkg::TW'(dv_quo);
      default:           t = '0;
    endcase
  end

  assign adx = dv_side.dx[psnd_pkg::DW-1] ? psnd_pkg::DW'(-dv_side.dx) : dv_side.dx;
  assign ady = dv_side.dy[psnd_pkg::DW-1] ? psnd_pkg::DW'(-dv_side.dy) : dv_side.dy;

  // floor toward minus infinity: round the magnitude up when the step is negative
  assign mbx = s1_side.dx[psnd_pkg::DW-1] ? (psnd_pkg::MW+1)'(s1_mx) + Bias
                                          : (psnd_pkg::MW+1)'(s1_mx);
  assign mby = s1_side.dy[psnd_pkg::DW-1] ? (psnd_pkg::MW+1)'(s1_my) + Bias
                                          : (psnd_pkg::MW+1)'(s1_my);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= dv_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side <= dv_side;
      s1_mx   <= psnd_pkg::MW'(t) * psnd_pkg::MW'(adx);
      s1_my   <= psnd_pkg::MW'(t) * psnd_pkg::MW'(ady);

      s2_side <= s1_side;
      s2_qx   <= mbx[psnd_pkg::TB +: psnd_pkg::DW];
      s2_qy   <= mby[psnd_pkg::TB +: psnd_pkg::DW];

      s3_side.degen <= s2_side.degen;
      s3_side.nx <= s2_side.dx[psnd_pkg::DW-1] ? s2_side.sx - psnd_pkg::CW'(s2_qx)
                                               : s2_side.sx + psnd_pkg::CW'(s2_qx);
      s3_side.ny <= s2_side.dy[psnd_pkg::DW-1] ? s2_side.sy - psnd_pkg::CW'(s2_qy)
                                               : s2_side.sy + psnd_pkg::CW'(s2_qy);
      s3_rx <= s2_side.dx[psnd_pkg::DW-1]
               ? psnd_pkg::RW'(s2_side.vx) + psnd_pkg::RW'({1'b0, s2_qx})
               : psnd_pkg::RW'(s2_side.vx) - psnd_pkg::RW'({1'b0, s2_qx});
      s3_ry <= s2_side.dy[psnd_pkg::DW-1]
               ? psnd_pkg::RW'(s2_side.vy) + psnd_pkg::RW'({1'b0, s2_qy})
               : psnd_pkg::RW'(s2_side.vy) - psnd_pkg::RW'({1'b0, s2_qy});

      s4_side <= s3_side;
      s4_ax   <= s3_rx[psnd_pkg::RW-1] ? psnd_pkg::DW'(-s3_rx) : psnd_pkg::DW'(s3_rx);
      s4_ay   <= s3_ry[psnd_pkg::RW-1] ? psnd_pkg::DW'(-s3_ry) : psnd_pkg::DW'(s3_ry);

      s5_side <= s4_side;
      s5_sx   <= s4_ax * s4_ax;
      s5_sy   <= s4_ay * s4_ay;

      s6_side <= s5_side;
      s6_sum  <= psnd_pkg::SQW'(s5_sx) + psnd_pkg::SQW'(s5_sy);
    end
  end

  psnd_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s6_valid),
    .radicand  (s6_sum),
    .in_side   (s6_side),
    .out_valid (rt_valid),
    .root_out  (rt_root),
    .side_out  (rt_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= rt_valid;
    end
  end

  // saturate the root to the distance field
  always_ff @(posedge clk) begin
    if (en) begin
      nearest_x  <= rt_side.nx;
      nearest_y  <= rt_side.ny;
      degenerate <= rt_side.degen;
      distance   <= (|(rt_root >> psnd_pkg::DSW)) ? '1 : psnd_pkg::DSW'(rt_root);
    end
  end

endmodule
`default_nettype wire

### design/point_segment_nearest_distance_top.sv
// Top level of the point to segment nearest distance block.
// Depends on psnd_pkg, psnd_front, psnd_queue and psnd_back.
//
// Each item is a query point and a segment, signed Q15.16; each result is the
// nearest point on the segment, the distance to it (Q17.16, rounded down,
// saturating) and a flag for coinciding end points. One item per clock is
// taken and one result per clock delivered when neither side stalls. An item
// passes through 3 front stages, the 4-entry queue, 34 divider stages (one
// quotient bit each), 6 scale and square stages, 34 square root stages and the
// output register. When the output stalls, the front keeps taking items until
// its queue and stages fill.
`default_nettype none
module point_segment_nearest_distance_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [psnd_pkg::CW-1:0] point_x,
  input  wire logic signed [psnd_pkg::CW-1:0] point_y,
  input  wire logic signed [psnd_pkg::CW-1:0] start_x,
  input  wire logic signed [psnd_pkg::CW-1:0] start_y,
  input  wire logic signed [psnd_pkg::CW-1:0] end_x,
  input  wire logic signed [psnd_pkg::CW-1:0] end_y,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [psnd_pkg::CW-1:0]      nearest_x,
  output logic signed [psnd_pkg::CW-1:0]      nearest_y,
  output logic [psnd_pkg::DSW-1:0]            distance,
  output logic                                degenerate
);

  logic               push, pop;
  psnd_pkg::q_entry_t entry, head;
  psnd_pkg::q_stat_t  q_stat;

  psnd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .point_x  (point_x),
    .point_y  (point_y),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .q_stat   (q_stat),
    .push     (push),
    .entry    (entry)
  );

  psnd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .entry  (entry),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  psnd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .nearest_x  (nearest_x),
    .nearest_y  (nearest_y),
    .distance   (distance),
    .degenerate (degenerate)
  );

endmodule
`default_nettype wire
